/* rtl/sha_pkg.sv */
`default_nettype none
package sha_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds = 64;
  localparam int DigestWords = 8;

  typedef struct packed {
    logic init_chain;
    logic start_block;
    logic round_en;
    logic finish_block;
  } sha_cmd_t;

  typedef logic [31:0] word_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t v;
    begin
      case (i)
        3'd0: v = 32'h6a09e667;
        3'd1: v = 32'hbb67ae85;
        3'd2: v = 32'h3c6ef372;
        3'd3: v = 32'ha54ff53a;
        3'd4: v = 32'h510e527f;
        3'd5: v = 32'h9b05688c;
        3'd6: v = 32'h1f83d9ab;
        default: v = 32'h5be0cd19;
      endcase
      return v;
    end
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    begin
      case (t)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/sha_datapath.sv */
`default_nettype none
module sha_datapath
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire sha_cmd_t    cmd,
  input  wire logic        wr_en,
  input  wire logic [5:0]  wr_addr,
  input  wire logic [7:0]  wr_data,
  input  wire logic [5:0]  round_idx,
  input  wire logic [2:0]  rd_word,
  output word_t            chain_word
);

  word_t store_r [BlockBytes/4];
  word_t chain_r [DigestWords];
  word_t v_r [8];
  word_t win_r [16];
  word_t w_new, t1, t2, s0, s1, ch, maj, ws0, ws1, w_blk;

  assign w_blk = store_r[round_idx[3:0]];

  always_comb begin
    ws0 = {win_r[1][6:0], win_r[1][31:7]} ^ {win_r[1][17:0], win_r[1][31:18]}
          ^ (win_r[1] >> 3);
    ws1 = {win_r[14][16:0], win_r[14][31:17]} ^ {win_r[14][18:0], win_r[14][31:19]}
          ^ (win_r[14] >> 10);
    w_new = (round_idx < 6'd16) ? w_blk : ws1 + win_r[9] + ws0 + win_r[0];
    s1 = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
         ^ {v_r[4][24:0], v_r[4][31:25]};
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    s0 = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
         ^ {v_r[0][21:0], v_r[0][31:22]};
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1 = v_r[7] + s1 + ch + round_k(round_idx) + w_new;
    t2 = s0 + maj;
  end

  // bytes land big-endian within each block word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr[5:2]][8*(3-wr_addr[1:0]) +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_chain) begin
      for (int i = 0; i < DigestWords; i++) chain_r[i] <= init_hash(3'(i));
    end else if (cmd.finish_block) begin
      for (int i = 0; i < DigestWords; i++) chain_r[i] <= chain_r[i] + v_r[i];
    end
    if (cmd.start_block) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
    end else if (cmd.round_en) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= w_new;
    end
  end

  assign chain_word = chain_r[rd_word];

endmodule
`default_nettype wire

/* rtl/sha_ctrl.sv */
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  input  wire logic        double_hash,
  output logic             busy,
  output sha_cmd_t         cmd,
  output logic             wr_en,
  output logic [5:0]       wr_addr,
  output logic [7:0]       wr_data,
  output logic [5:0]       round_idx,
  output logic [2:0]       rd_word,
  input  wire word_t       chain_word,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_word,
  output logic [2:0]       out_index
);

  localparam logic [3:0] S_IDLE = 4'd0, S_START = 4'd1, S_ROUND = 4'd2, S_FIN = 4'd3,
    S_PAD = 4'd4, S_DCOPY = 4'd5, S_OUT = 4'd6, S_WAIT = 4'd7;

  logic [3:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt, rnd_r, rnd_nxt, pad_r, pad_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        ending_r, ending_nxt, lastblk_r, lastblk_nxt, dbl_r, dbl_nxt;
  logic [3:0]  oi_r, oi_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] ow_r, ow_nxt;
  logic [2:0]  ox_r, ox_nxt;
  logic [63:0] len_v;

  assign in_tready = (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE) || ov_r;
  assign round_idx = rnd_r;
  assign rd_word = oi_r[2:0];
  assign out_tvalid = ov_r;
  assign out_word = ow_r;
  assign out_index = ox_r;
  assign len_v = dbl_r ? 64'd256 : bits_r;

  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; rnd_nxt = rnd_r; pad_nxt = pad_r;
    bits_nxt = bits_r; ending_nxt = ending_r; lastblk_nxt = lastblk_r; dbl_nxt = dbl_r;
    oi_nxt = oi_r; ov_nxt = ov_r; ow_nxt = ow_r; ox_nxt = ox_r;
    cmd = '0; wr_en = 1'b0; wr_addr = fill_r; wr_data = data_byte;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ending_nxt = end_of_message;
          if (byte_present) begin
            wr_en = 1'b1;
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
          end
          if (byte_present && fill_r == 6'd63) begin
            lastblk_nxt = 1'b0;
            state_nxt = S_START;
          end else if (end_of_message) begin
            pad_nxt = byte_present ? fill_r + 6'd1 : fill_r;
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        wr_en = 1'b1;
        wr_addr = pad_r;
        if (pad_r >= 6'd56 && lastblk_r) wr_data = len_v[8*(63-pad_r) +: 8];
        else if (pad_r == fill_r) wr_data = 8'h80;
        else wr_data = 8'h00;
        pad_nxt = pad_r + 6'd1;
        if (pad_r == 6'd63) begin
          state_nxt = S_START;
        end else if (pad_r == 6'd55 && fill_r < 6'd56) begin
          lastblk_nxt = 1'b1;
        end
        if (pad_r == 6'd63 && !lastblk_r && fill_r < 6'd56) lastblk_nxt = 1'b1;
      end
      S_START: begin
        cmd.start_block = 1'b1;
        rnd_nxt = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish_block = 1'b1;
        if (!ending_r) begin
          state_nxt = S_IDLE;
        end else if (!lastblk_r) begin
          pad_nxt = 6'd0;
          lastblk_nxt = 1'b1;
          state_nxt = S_PAD;
        end else if (double_hash && !dbl_r) begin
          dbl_nxt = 1'b1;
          oi_nxt = 4'd0;
          state_nxt = S_DCOPY;
        end else begin
          oi_nxt = 4'd0;
          state_nxt = S_OUT;
        end
      end
      S_DCOPY: begin
        wr_en = 1'b1;
        wr_addr = {1'b0, oi_r[2:0], pad_r[1:0]};
        wr_data = chain_word[8*(3-pad_r[1:0]) +: 8];
        pad_nxt = pad_r + 6'd1;
        if (pad_r[1:0] == 2'd3) begin
          oi_nxt = oi_r + 4'd1;
          if (oi_r == 4'd7) begin
            cmd.init_chain = 1'b1;
            fill_nxt = 6'd32;
            pad_nxt = 6'd32;
            lastblk_nxt = 1'b1;
            state_nxt = S_PAD;
          end
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          ow_nxt = chain_word;
          ox_nxt = oi_r[2:0];
          oi_nxt = oi_r + 4'd1;
          if (oi_r == 4'd7) state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.init_chain = 1'b1;
        fill_nxt = 6'd0; bits_nxt = '0; dbl_nxt = 1'b0; ending_nxt = 1'b0;
        lastblk_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_FIN && ending_r && !lastblk_r) pad_nxt = 6'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT; fill_r <= '0; bits_r <= '0; ending_r <= 1'b0;
      lastblk_r <= 1'b0; dbl_r <= 1'b0; ov_r <= 1'b0; oi_r <= '0; rnd_r <= '0;
      pad_r <= '0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; bits_r <= bits_nxt;
      ending_r <= ending_nxt; lastblk_r <= lastblk_nxt; dbl_r <= dbl_nxt;
      ov_r <= ov_nxt; oi_r <= oi_nxt; rnd_r <= rnd_nxt; pad_r <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ow_r <= ow_nxt;
    ox_r <= ox_nxt;
  end

endmodule
`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
`default_nettype none
// channel | direction | payload
// in_     | in        | tdata: data_byte[7:0]; tuser: byte_present; tlast: end_of_message
// out_    | out       | tdata: digest_word[31:0]; tuser: word_index[2:0]; tlast: last_word
// cfg_    | in        | tdata: double_hash[0]; ready only while idle with no beat pending
// byte beats are taken back to back while idle; the 64th byte of a block holds in_tready low
// through compression (start, 64 rounds, feed-forward)
// end of message: per block a padding sweep of up to 64 bytes plus compression,
// one or two blocks; double hashing adds a block (32 bytes copied, 32 bytes padded, compression)
// then eight output beats and a restart state; out_tready low stalls the output register
// reset is synchronous active low
module sha256_stream_hasher
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // byte_present
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // digest_word
  output logic [2:0]       out_tuser,  // word_index
  output logic             out_tlast,
  input  wire logic        cfg_tvalid,
  output logic             cfg_tready,
  input  wire logic [7:0]  cfg_tdata   // double_hash
);

  sha_cmd_t    cmd;
  logic        wr_en, busy, dbl_r;
  logic [5:0]  wr_addr, round_idx;
  logic [7:0]  wr_data;
  logic [2:0]  rd_word;
  word_t       chain_word;

  assign cfg_tready = !busy;
  assign out_tlast = (out_tuser == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_r <= 1'b0;
    end else if (cfg_tvalid && cfg_tready) begin
      dbl_r <= cfg_tdata[0];
    end
  end

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .data_byte(in_tdata), .byte_present(in_tuser), .end_of_message(in_tlast),
    .double_hash(dbl_r), .busy, .cmd, .wr_en, .wr_addr, .wr_data, .round_idx,
    .rd_word, .chain_word, .out_tvalid, .out_tready, .out_word(out_tdata),
    .out_index(out_tuser)
  );

  sha_datapath u_dp (
    .clk, .cmd, .wr_en, .wr_addr, .wr_data, .round_idx, .rd_word, .chain_word
  );

endmodule
`default_nettype wire

/* sim/tb_top.sv */
module tb_top;
  import sha_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // data_byte
  logic        in_tuser;   // byte_present
  logic        in_tlast;   // end_of_message
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // digest_word
  logic [2:0]  out_tuser;  // word_index
  logic        out_tlast;  // last_word
  logic        cfg_tvalid;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata;  // double_hash

  sha256_stream_hasher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
  );

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
    logic       check_digest;
    word_t      digest0;
  } stim_row_t;

  // predictor state
  word_t       chain[8];
  logic [7:0]  block_buf[64];
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic        dbl_mode;

  digest_beat_t digest_q[$];
  word_t        known_first_q[$];
  int errors;
  int cycle_cnt;
  bit quiet;
  bit hold_off_req;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t iv_word(int i);
    word_t ivs[8];
    ivs = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return ivs[i];
  endfunction

  function automatic word_t k_const(int t);
    word_t kt[64];
    kt = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return kt[t];
  endfunction

  task automatic fold_block();
    word_t v[8];
    word_t w[64];
    word_t s0, s1, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
      end else begin
        s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
        s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(t) + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic put_len(logic [63:0] bits);
    for (int i = 0; i < 8; i++) block_buf[56+i] = bits[63-8*i -: 8];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain[i] = iv_word(i);
    fill = '0;
    msg_bits = '0;
  endtask

  task automatic predict_beat(logic [7:0] data, logic has_byte, logic eom);
    int p;
    word_t dg[8];
    if (has_byte) begin
      block_buf[fill] = data;
      msg_bits += 64'd8;
      fill++;
      if (fill == 0) fold_block();
    end
    if (!eom) return;
    p = fill;
    block_buf[p++] = 8'h80;
    if (p > 56) begin
      while (p < 64) block_buf[p++] = 8'h00;
      fold_block();
      p = 0;
    end
    while (p < 56) block_buf[p++] = 8'h00;
    put_len(msg_bits);
    fold_block();
    if (dbl_mode) begin
      for (int i = 0; i < 8; i++) dg[i] = chain[i];
      for (int i = 0; i < 8; i++) begin
        chain[i] = iv_word(i);
        {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]} = dg[i];
      end
      block_buf[32] = 8'h80;
      for (int i = 33; i < 56; i++) block_buf[i] = 8'h00;
      put_len(64'd256);
      fold_block();
    end
    for (int i = 0; i < 8; i++) digest_q.push_back({chain[i], 3'(i), i == 7});
    restart_hash();
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("FAIL sha256_stream_hasher");
    $finish;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // result checker
  always @(posedge clk) begin
    digest_beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser, out_tlast};
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest beat %h", got);
      end else begin
        want = digest_q.pop_front();
        if (want.index == 0 && known_first_q.size() > 0) begin
          if (known_first_q.pop_front() != got.word) begin
            errors++;
            if (errors <= 10) $display("known digest word0 mismatch got %h", got.word);
          end
        end
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch exp w=%h i=%0d l=%b got w=%h i=%0d l=%b",
                     want.word, want.index, want.last, got.word, got.index, got.last);
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int n;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 0;
        repeat (3000) @(negedge clk);
        hold_off_req = 0;
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        n = $urandom_range(1, 6);
        repeat (n) @(negedge clk);
      end
      out_tready <= 1;
    end
  end

  task automatic send_beat(logic [7:0] data, logic has_byte, logic eom);
    in_tvalid <= 1;
    in_tdata <= data;
    in_tuser <= has_byte;
    in_tlast <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beat(data, has_byte, eom);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (digest_q.size() > 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_mode(logic val);
    cfg_tvalid <= 1;
    cfg_tdata <= {7'($urandom_range(0, 127)), val};
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    dbl_mode = val;
    @(negedge clk);
    cfg_tvalid <= 0;
  endtask

  task automatic send_message(int len, int kind);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (kind == 0) ? 8'($urandom) : (kind == 1 ? 8'h00 : 8'hff);
      if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 0, 0);
      send_beat(b, 1, (i == len - 1) && ($urandom_range(0, 1) == 1));
      if (i == len - 1 && in_tlast == 0) send_beat(8'($urandom), 0, 1);
    end
    if (len == 0) send_beat(8'($urandom), 0, 1);
  endtask

  stim_row_t dir_rows[$];
  int accepted;

  initial begin
    stim_row_t r;
    errors = 0;
    cycle_cnt = 0;
    quiet = 0;
    hold_off_req = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = '0;
    cfg_tvalid = 0;
    cfg_tdata = '0;
    dbl_mode = 0;
    restart_hash();
    for (int i = 0; i < 64; i++) block_buf[i] = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty message, "abc", idle beat, byte with end, 0x00/0xff
    dir_rows.push_back('{8'h00, 0, 1, 1, 32'he3b0c442});
    dir_rows.push_back('{8'h5a, 0, 0, 0, 0});
    dir_rows.push_back('{8'h61, 1, 0, 0, 0});
    dir_rows.push_back('{8'h62, 1, 0, 0, 0});
    dir_rows.push_back('{8'h63, 1, 1, 1, 32'hba7816bf});
    dir_rows.push_back('{8'h00, 1, 1, 0, 0});
    dir_rows.push_back('{8'hff, 1, 0, 0, 0});
    dir_rows.push_back('{8'hff, 1, 0, 0, 0});
    dir_rows.push_back('{8'h00, 0, 1, 0, 0});
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.check_digest) known_first_q.push_back(r.digest0);
      send_beat(r.data, r.has_byte, r.eom);
    end
    // lengths around the padding boundary and block edges
    send_message(55, 1);
    send_message(56, 2);
    send_message(63, 0);
    send_message(64, 2);
    send_message(65, 0);
    drain();

    // double hash of empty message
    write_mode(1);
    known_first_q.push_back(32'h5df6e0e2);
    send_beat(8'h00, 0, 1);
    send_message(57, 0);
    send_message(1, 2);
    // long receiver hold-off while sender keeps going
    hold_off_req = 1;
    send_message(20, 0);
    send_message(3, 0);
    send_message(10, 0);
    drain();

    accepted = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      for (int m = 0; m < 2; m++) begin
        if (ph == 3) quiet = 1;
        send_message(($urandom_range(0, 7) == 0) ? $urandom_range(60, 90)
                     : $urandom_range(0, 10), 0);
      end
      drain();
    end
    write_mode(0);
    send_message(5, 0);
    drain();

    if (errors == 0 && digest_q.size() == 0) begin
      $display("PASS sha256_stream_hasher");
    end else begin
      $display("FAIL sha256_stream_hasher");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sha_pkg.sv
rtl/sha_datapath.sv
rtl/sha_ctrl.sv
rtl/sha256_stream_hasher.sv
sim/tb_top.sv
